### hdl/segmented_block_id_remap_top_assert.svh
// Assertion macros for the segmented block id remapper checker.
// Depends on a clk and an arst_n signal in the scope of use.
`ifndef SEGMENTED_BLOCK_ID_REMAP_TOP_ASSERT_SVH
`define SEGMENTED_BLOCK_ID_REMAP_TOP_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define SBR_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("segmented block id remap: assertion failed");

// Antecedent implies consequent in the next cycle.
`define SBR_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("segmented block id remap: assertion failed");

`endif

### hdl/sbr_pkg.sv
// Shared types and constants of the segmented block id remapper.
// No dependencies.
package sbr_pkg;

	localparam int SEG_REGS = 6;
	localparam int BS_W     = 32;
	localparam int LEN_W    = 32;
	localparam int CNT_W    = 3;
	localparam int TOT_W    = 35;
	localparam int OUT_W    = 48;
	localparam int IDX_W    = 3;
	localparam int HALF_W   = 24;

	localparam logic [IDX_W-1:0] REG_BLOCK_SIZE = 3'd0;
	localparam logic [IDX_W-1:0] REG_SEG_COUNT  = 3'd1;
	localparam logic [IDX_W-1:0] REG_SEG_FIRST  = 3'd2;

	// Configuration as seen by the datapath, with the prefix sums worked out.
	typedef struct packed {
		logic [BS_W-1:0]                 bsize;
		logic [CNT_W-1:0]                seg_n;
		logic [TOT_W-1:0]                total;
		logic [SEG_REGS-1:0][TOT_W-1:0]  stop;
	} sbr_cfg_t;

endpackage

### hdl/sbr_in_if.sv
// Input channel of the remapper: one row id per transaction.
// No dependencies.
interface sbr_in_if #(parameter int ID_WIDTH = 32);
	logic                valid;
	logic                ready;
	logic [ID_WIDTH-1:0] row_id;

	modport source (output valid, output row_id, input ready);
	modport sink (input valid, input row_id, output ready);
endinterface

### hdl/sbr_out_if.sv
// Output channel of the remapper: mapped id and error flag per transaction.
// No dependencies.
interface sbr_out_if;
	logic        valid;
	logic        ready;
	logic [47:0] mapped_id;
	logic        error;

	modport source (output valid, output mapped_id, output error, input ready);
	modport sink (input valid, input mapped_id, input error, output ready);
endinterface

### hdl/sbr_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// No dependencies.
module sbr_div #(
	parameter int N    = 32,
	parameter int D    = 32,
	parameter int SB_W = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [N-1:0]    num,
	input  logic [SB_W-1:0] sb_in,
	input  logic [D-1:0]    divisor,
	output logic            out_valid,
	output logic [N-1:0]    quo,
	output logic [D-1:0]    rem,
	output logic [SB_W-1:0] sb_out
);

	logic [N-1:0]    num_s [1:N];
	logic [D-1:0]    rem_s [1:N];
	logic [SB_W-1:0] sb_s  [1:N];
	logic            v_s   [1:N];

	for (genvar i = 0; i < N; i++) begin : g_st
		logic [N-1:0]    n_in;
		logic [D-1:0]    r_in;
		logic [SB_W-1:0] b_in;
		logic            v_in;
		logic [D:0]      trial;
		logic            fit;

		if (i == 0) begin : g_first
			assign n_in = num;
			assign r_in = '0;
			assign b_in = sb_in;
			assign v_in = in_valid;
		end else begin : g_next
			assign n_in = num_s[i];
			assign r_in = rem_s[i];
			assign b_in = sb_s[i];
			assign v_in = v_s[i];
		end

		assign trial = {r_in, n_in[N-1]};
		assign fit   = trial >= {1'b0, divisor};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[i+1] <= {n_in[N-2:0], fit};
				rem_s[i+1] <= fit ? D'(trial - {1'b0, divisor}) : D'(trial);
				sb_s[i+1]  <= b_in;
			end
		end
	end

	assign out_valid = v_s[N];
	assign quo       = num_s[N];
	assign rem       = rem_s[N];
	assign sb_out    = sb_s[N];

endmodule

### hdl/sbr_map.sv
// Back end of the remapper: segment search, period scaling and final sum.
// Depends on sbr_pkg.
module sbr_map #(
	parameter int ID_WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  sbr_pkg::sbr_cfg_t       cfg,
	input  logic                    in_valid,
	input  logic [sbr_pkg::TOT_W-1:0] rel,
	input  logic [ID_WIDTH-1:0]     period,
	input  logic [sbr_pkg::BS_W-1:0] col,
	input  logic                    err,
	output logic                    out_valid,
	output logic [sbr_pkg::OUT_W-1:0] mapped_id,
	output logic                    error
);
	import sbr_pkg::*;

	localparam int PW = ID_WIDTH + CNT_W;

	logic [CNT_W-1:0] seg;
	logic [PW-1:0]    pn;

	logic             v_s1, v_s2, v_s3, v_q;
	logic [CNT_W-1:0] seg_s1;
	logic [OUT_W-1:0] pn_s1, q_s2;
	logic [BS_W-1:0]  col_s1, col_s2, col_s3;
	logic             err_s1, err_s2, err_s3;
	logic [HALF_W+BS_W-1:0] lo_s3;
	logic [HALF_W-1:0]      hi_s3;
	logic [OUT_W-1:0] mapped_q;
	logic             error_q;

	// Lowest segment whose prefix sum lies above the offset; last in use otherwise.
	always_comb begin
		seg = cfg.seg_n - CNT_W'(1);
		for (int i = SEG_REGS - 2; i >= 0; i--) begin
			if ((i + 1 < int'(cfg.seg_n)) && (rel < cfg.stop[i])) begin
				seg = CNT_W'(i);
			end
		end
	end

	assign pn = PW'(period) * PW'(cfg.seg_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_q  <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_q  <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			seg_s1   <= seg;
			pn_s1    <= OUT_W'(pn);
			col_s1   <= col;
			err_s1   <= err || (cfg.bsize == '0) || (cfg.total == '0);
			q_s2     <= pn_s1 + OUT_W'(seg_s1);
			col_s2   <= col_s1;
			err_s2   <= err_s1;
			lo_s3    <= q_s2[HALF_W-1:0] * cfg.bsize;
			hi_s3    <= HALF_W'(q_s2[OUT_W-1:HALF_W] * cfg.bsize[HALF_W-1:0]);
			col_s3   <= col_s2;
			err_s3   <= err_s2;
			mapped_q <= err_s3 ? OUT_W'(1)
				: OUT_W'(lo_s3) + {hi_s3, {HALF_W{1'b0}}} + OUT_W'(col_s3) + OUT_W'(1);
			error_q  <= err_s3;
		end
	end

	assign out_valid = v_q;
	assign mapped_id = mapped_q;
	assign error     = error_q;

endmodule

### hdl/segmented_block_id_remap_top.sv
// Top level of the segmented block id remapper: configuration registers and pipeline.
// Depends on sbr_pkg, sbr_in_if, sbr_out_if, sbr_div and sbr_map.
//
// The block takes one one-based row id per transaction and returns one mapped
// id per transaction, in order. It accepts a new row id in every cycle; the
// pipeline is made up of an entry register, two dividers of ID_WIDTH stages
// each, with one quotient bit per stage, and then four back-end stages.
// The whole pipeline advances together whenever the output register is empty
// or being emptied, so a stall on the output side holds every stage in place
// and the input is not ready for as long as that stall lasts.
// The first divider splits the row offset into block row and column by the
// block size; the second splits the block row into period and offset by the
// total segment length. The offset is placed in its segment against prefix
// sums that are kept in registers beside the configuration; the final id is
// built with two narrow multipliers whose partial products are summed in the
// last stage. A zero row id, block size or total length gives error and an id
// of one. Configuration is written through cfg_we, cfg_index and cfg_data and
// must only change while no transaction is in flight; the prefix sums are
// registered and follow in the cycle after a write.
module segmented_block_id_remap_top #(
	parameter int MAX_SEGMENTS = 6,
	parameter int ID_WIDTH     = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [sbr_pkg::IDX_W-1:0] cfg_index,
	input  logic [sbr_pkg::LEN_W-1:0] cfg_data,
	sbr_in_if.sink                   in_ch,
	sbr_out_if.source                out_ch
);
	import sbr_pkg::*;

	// Raw configuration registers.
	logic [BS_W-1:0]  bsize_q;
	logic [CNT_W-1:0] seg_count_q;
	logic [LEN_W-1:0] seg_len_q [SEG_REGS];

	// Derived configuration: saturated count, prefix sums and total.
	sbr_cfg_t cfg_d, cfg_q;

	logic en;
	logic out_valid;

	// Entry stage.
	logic                v_s0;
	logic [ID_WIDTH-1:0] k_s0;
	logic                err_s0;

	// Between the dividers and the back end.
	logic                d1_valid, d2_valid, d1_err;
	logic [ID_WIDTH-1:0] d1_quo, d2_quo;
	logic [BS_W-1:0]     d1_rem;
	logic [TOT_W-1:0]    d2_rem;
	logic [BS_W:0]       d2_sb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bsize_q     <= BS_W'(1);
			seg_count_q <= CNT_W'(1);
			for (int i = 0; i < SEG_REGS; i++) begin
				seg_len_q[i] <= (i == 0) ? LEN_W'(1) : '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BLOCK_SIZE: bsize_q     <= cfg_data;
				REG_SEG_COUNT:  seg_count_q <= cfg_data[CNT_W-1:0];
				default:        seg_len_q[cfg_index - REG_SEG_FIRST] <= cfg_data;
			endcase
		end
	end

	// The count saturates at the number of segments built in; segments beyond
	// the count take no part in the sums.
	always_comb begin
		logic [TOT_W-1:0] acc;
		acc = '0;
		cfg_d.bsize = bsize_q;
		cfg_d.seg_n = (int'(seg_count_q) > MAX_SEGMENTS) ? CNT_W'(MAX_SEGMENTS) : seg_count_q;
		for (int i = 0; i < SEG_REGS; i++) begin
			if (i < int'(cfg_d.seg_n)) begin
				acc = acc + TOT_W'(seg_len_q[i]);
			end
			cfg_d.stop[i] = acc;
		end
		cfg_d.total = acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bsize <= BS_W'(1);
			cfg_q.seg_n <= CNT_W'(1);
			cfg_q.total <= TOT_W'(1);
			cfg_q.stop  <= {SEG_REGS{TOT_W'(1)}};
		end else begin
			cfg_q <= cfg_d;
		end
	end

	// One stall signal for the whole pipeline.
	assign en          = !out_valid || out_ch.ready;
	assign in_ch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else if (en) begin
			v_s0 <= in_ch.valid;
		end
	end

	// Only the zero row id is flagged here; the checks on the configuration are
	// made in the back end, where the derived registers have settled.
	always_ff @(posedge clk) begin
		if (en) begin
			k_s0   <= in_ch.row_id - ID_WIDTH'(1);
			err_s0 <= (in_ch.row_id == '0);
		end
	end

	sbr_div #(
		.N    (ID_WIDTH),
		.D    (BS_W),
		.SB_W (1)
	) u_div_row (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s0),
		.num       (k_s0),
		.sb_in     (err_s0),
		.divisor   (cfg_q.bsize),
		.out_valid (d1_valid),
		.quo       (d1_quo),
		.rem       (d1_rem),
		.sb_out    (d1_err)
	);

	sbr_div #(
		.N    (ID_WIDTH),
		.D    (TOT_W),
		.SB_W (BS_W + 1)
	) u_div_period (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (d1_valid),
		.num       (d1_quo),
		.sb_in     ({d1_err, d1_rem}),
		.divisor   (cfg_q.total),
		.out_valid (d2_valid),
		.quo       (d2_quo),
		.rem       (d2_rem),
		.sb_out    (d2_sb)
	);

	sbr_map #(
		.ID_WIDTH (ID_WIDTH)
	) u_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.cfg       (cfg_q),
		.in_valid  (d2_valid),
		.rel       (d2_rem),
		.period    (d2_quo),
		.col       (d2_sb[BS_W-1:0]),
		.err       (d2_sb[BS_W]),
		.out_valid (out_valid),
		.mapped_id (out_ch.mapped_id),
		.error     (out_ch.error)
	);

	assign out_ch.valid = out_valid;

endmodule

### hdl/sbr_check.sv
// Port-level checker for the segmented block id remapper, bound to the top level.
// Depends on sbr_pkg and segmented_block_id_remap_top_assert.svh.
`include "segmented_block_id_remap_top_assert.svh"

module sbr_check (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [sbr_pkg::OUT_W-1:0] mapped_id,
	input logic                      error
);
	import sbr_pkg::*;

	// A stalled result keeps its values.
	`SBR_ASSERT_NXT(a_hold, out_valid && !out_ready, $stable({out_valid, mapped_id, error}))

	// Flagged results always carry an id of one.
	`SBR_ASSERT_IMP(a_err_id, out_valid && error, mapped_id == OUT_W'(1))

	// The input is held off exactly while a result waits to be taken.
	`SBR_ASSERT_IMP(a_ready, 1'b1, in_ready == (!out_valid || out_ready))

endmodule

bind segmented_block_id_remap_top sbr_check u_sbr_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.mapped_id (out_ch.mapped_id),
	.error     (out_ch.error)
);

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the segmented block id remapper.
// Depends on sbr_pkg, sbr_in_if, sbr_out_if and segmented_block_id_remap_top.
module tb;
	import sbr_pkg::*;

	localparam int ID_W = 32;
	// The settle pause is kept longer than the pipeline is deep.
	localparam int DRAIN_CYCLES = 2 * ID_W + 20;
	localparam int STALL_LIMIT = 20000;

	// The three configuration indexes that the package names, and the last one.
	localparam logic [IDX_W-1:0] REG_SEG_LAST = 3'd7;

	typedef struct {
		logic [OUT_W-1:0] mapped_id;
		logic             error;
	} remap_t;

	// Directed row: a row id and, where it is obvious, a typed-in result.
	typedef struct {
		logic [ID_W-1:0]  row_id;
		logic             typed;
		logic [OUT_W-1:0] mapped_id;
		logic             error;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [LEN_W-1:0] cfg_data;

	sbr_in_if #(.ID_WIDTH(ID_W)) in_ch ();
	sbr_out_if out_ch ();

	segmented_block_id_remap_top #(.MAX_SEGMENTS(6), .ID_WIDTH(ID_W)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// The testbench's own view of the configuration registers.
	logic [31:0] blk_size;
	logic [2:0]  seg_cnt;
	logic [31:0] seg_len [SEG_REGS];

	// Mapped ids still owed by the block, oldest first.
	remap_t pending_ids[$];

	int  fails;
	int  idle_pct;     // percentage of cycles in which each side idles
	bit  hold_sink;    // the long hold-off on the output side
	bit  hold_sink_req;
	int  quiet_cycles;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// The remap itself, worked out in 64-bit arithmetic as the block defines it.
	function automatic remap_t remap_row(input logic [ID_W-1:0] row_id);
		remap_t res;
		logic [63:0] n, total, k, r, col, rel, period, seg, stop, full;
		n = (seg_cnt > 3'd6) ? 64'd6 : 64'(seg_cnt);
		total = 0;
		for (int i = 0; i < n; i++)
			total += seg_len[i];
		if (row_id == 0 || blk_size == 0 || total == 0) begin
			res.mapped_id = 1;
			res.error = 1'b1;
			return res;
		end
		k = 64'(row_id) - 1;
		r = k / blk_size;
		col = k % blk_size;
		rel = r % total;
		period = r / total;
		seg = n - 1;
		stop = 0;
		for (int i = 0; i + 1 < n; i++) begin
			stop += seg_len[i];
			if (rel < stop) begin
				seg = i;
				break;
			end
		end
		full = col + (seg + period * n) * 64'(blk_size) + 1;
		res.mapped_id = full[OUT_W-1:0];
		res.error = 1'b0;
		return res;
	endfunction

	// One register write; the write enable is dropped again before the task returns.
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_BLOCK_SIZE)
			blk_size = val;
		else if (idx == REG_SEG_COUNT)
			seg_cnt = val[2:0];
		else
			seg_len[idx - REG_SEG_FIRST] = val;
		@(posedge clk);
	endtask

	// Waits until the block has returned everything and then lets it settle,
	// so that a register write never lands on a transaction in flight.
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (pending_ids.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Offers one row id, idling first at random, and holds it until it is taken.
	// The expectation is queued at the accepting edge, before the result can appear.
	task automatic send_row(input logic [ID_W-1:0] row_id, input bit typed,
			input remap_t typed_res);
		remap_t res;
		while ($urandom_range(99) < idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.row_id <= row_id;
		@(posedge clk iff in_ch.ready);
		res = remap_row(row_id);
		if (typed && (res.mapped_id !== typed_res.mapped_id
				|| res.error !== typed_res.error)) begin
			// A typed-in row that disagrees with the predictor is a bench fault.
			$display("%0t: typed result disagrees for row %0d", $realtime, row_id);
			fails++;
		end
		pending_ids.push_back(typed ? typed_res : res);
	endtask

	// Random row id: mostly small ids from 1 to 400, sometimes any value, zero or one of the largest.
	function automatic logic [ID_W-1:0] rand_row();
		case ($urandom_range(9))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF - $urandom_range(3);
			2, 3: return $urandom;
			default: return $urandom_range(1, 400);
		endcase
	endfunction

	// A random setting, most of it small so that periods and segments vary.
	task automatic random_config();
		write_reg(REG_BLOCK_SIZE, ($urandom_range(19) == 0) ? $urandom
				: ($urandom_range(29) == 0 ? 32'd0 : $urandom_range(1, 9)));
		write_reg(REG_SEG_COUNT, $urandom_range(7));
		for (int i = 0; i < SEG_REGS; i++)
			write_reg(REG_SEG_FIRST + i[IDX_W-1:0], ($urandom_range(24) == 0)
					? $urandom : $urandom_range(0, 6));
	endtask

	// Output side: idles at random and holds off completely on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= !hold_sink && ($urandom_range(99) >= idle_pct);
		end
	end

	// Long hold-off on the output side, counted in this process alone.
	always @(posedge clk) begin
		if (hold_sink_req && !hold_sink) begin
			hold_sink <= 1'b1;
			repeat (300) @(posedge clk);
			hold_sink <= 1'b0;
		end
	end

	// Compares each returned transaction with the oldest expectation.
	always @(posedge clk) begin
		remap_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_ids.size() == 0) begin
				$display("%0t: unexpected result, actual id %0d error %0b", $realtime,
						out_ch.mapped_id, out_ch.error);
				fails++;
			end else begin
				want = pending_ids.pop_front();
				if (out_ch.mapped_id !== want.mapped_id) begin
					$display("%0t: mapped_id expected %0d actual %0d", $realtime,
							want.mapped_id, out_ch.mapped_id);
					fails++;
				end
				if (out_ch.error !== want.error) begin
					$display("%0t: error expected %0b actual %0b", $realtime,
							want.error, out_ch.error);
					fails++;
				end
			end
		end
	end

	// Watchdog: counts cycles in which neither channel completes a transaction.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		dir_row_t rows[$];
		remap_t   typed_res;
		fails = 0;
		quiet_cycles = 0;
		idle_pct = 37;
		hold_sink = 1'b0;
		hold_sink_req = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.row_id = '0;
		blk_size = 1;
		seg_cnt = 1;
		foreach (seg_len[i])
			seg_len[i] = 0;
		seg_len[0] = 1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, first under the reset setting: the map is the identity,
		// so each row id comes back as itself and zero is the error case.
		rows = '{
			'{32'd0, 1'b1, 48'd1, 1'b1},
			'{32'd1, 1'b1, 48'd1, 1'b0},
			'{32'd2, 1'b1, 48'd2, 1'b0},
			'{32'hFFFF_FFFF, 1'b1, 48'hFFFF_FFFF, 1'b0},
			'{32'h8000_0000, 1'b1, 48'h8000_0000, 1'b0}
		};
		foreach (rows[i]) begin
			typed_res.mapped_id = rows[i].mapped_id;
			typed_res.error = rows[i].error;
			send_row(rows[i].row_id, rows[i].typed, typed_res);
		end
		wait_drained();

		// Three segments of 2, 0 and 3 rows, blocks of 4: rows hit both non-empty
		// segments, pass over the empty one and reach later periods.
		write_reg(REG_BLOCK_SIZE, 32'd4);
		write_reg(REG_SEG_COUNT, 3'd3);
		write_reg(REG_SEG_FIRST, 32'd2);
		write_reg(REG_SEG_FIRST + 3'd1, 32'd0);
		write_reg(REG_SEG_FIRST + 3'd2, 32'd3);
		write_reg(REG_SEG_FIRST + 3'd3, 32'd9);
		write_reg(REG_SEG_FIRST + 3'd4, 32'd9);
		write_reg(REG_SEG_LAST, 32'd9);
		for (int id = 1; id <= 24; id += 3)
			send_row(id, 1'b0, typed_res);
		send_row(32'hFFFF_FFFF, 1'b0, typed_res);
		wait_drained();

		// A segment count above the maximum saturates to six segments;
		// largest block size and largest segment lengths.
		write_reg(REG_SEG_COUNT, 3'd7);
		send_row(32'd77, 1'b0, typed_res);
		wait_drained();
		write_reg(REG_BLOCK_SIZE, 32'hFFFF_FFFF);
		for (int i = 0; i < SEG_REGS; i++)
			write_reg(REG_SEG_FIRST + i[IDX_W-1:0], 32'hFFFF_FFFF);
		send_row(32'hFFFF_FFFF, 1'b0, typed_res);
		send_row(32'd1, 1'b0, typed_res);
		wait_drained();

		// A zero segment count and a zero block size are error cases.
		write_reg(REG_SEG_COUNT, 3'd0);
		typed_res.mapped_id = 1;
		typed_res.error = 1'b1;
		send_row(32'd5, 1'b1, typed_res);
		wait_drained();
		write_reg(REG_SEG_COUNT, 3'd2);
		write_reg(REG_BLOCK_SIZE, 32'd0);
		send_row(32'd5, 1'b1, typed_res);
		wait_drained();

		// Zero total length with segments in use.
		write_reg(REG_BLOCK_SIZE, 32'd3);
		write_reg(REG_SEG_FIRST, 32'd0);
		write_reg(REG_SEG_FIRST + 3'd1, 32'd0);
		send_row(32'd5, 1'b1, typed_res);
		wait_drained();

		// Random part in phases, each with a fresh setting. One phase has no
		// idling at all; one holds the output side off while rows keep coming.
		for (int phase = 0; phase < 31; phase++) begin
			random_config();
			idle_pct = (phase == 5) ? 0 : 37;
			if (phase == 9)
				hold_sink_req = 1'b1;
			for (int i = 0; i < 50; i++) begin
				send_row(rand_row(), 1'b0, typed_res);
				if (phase == 9 && hold_sink)
					hold_sink_req = 1'b0;
				// Once, in phase 12, the sender pauses until every result is back.
				if (phase == 12 && i == 25) begin
					in_ch.valid <= 1'b0;
					do
						@(posedge clk);
					while (pending_ids.size() != 0);
				end
			end
			hold_sink_req = 1'b0;
			wait_drained();
		end

		if (fails == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule

### files.f
+incdir+hdl
hdl/sbr_pkg.sv
hdl/sbr_in_if.sv
hdl/sbr_out_if.sv
hdl/sbr_div.sv
hdl/sbr_map.sv
hdl/segmented_block_id_remap_top.sv
hdl/sbr_check.sv
tb/sv/tb.sv
